// ===== hdl/cbs_pkg.sv =====
`default_nettype none

package cbs_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_CAMERA_VARIANT    = 3'd0;
  localparam logic [2:0] REG_PRESS_TICKS       = 3'd1;
  localparam logic [2:0] REG_HOLD_TICKS        = 3'd2;
  localparam logic [2:0] REG_BLINK_TICKS       = 3'd3;
  localparam logic [2:0] REG_LIGHT_CHECK_TICKS = 3'd4;
  localparam logic [2:0] REG_STALL_TICKS       = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Counter widths.
  localparam int STALL_W = 16;
  localparam int BLINK_W = 8;
  localparam int LIGHT_W = 12;
  localparam int MODE_W  = 8;
  localparam int HOLD_W  = 10;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  // Bit positions of the input fields in in_tdata.
  localparam int IN_MODE_BIT    = 0;
  localparam int IN_RESET_BIT   = 1;
  localparam int IN_READY_BIT   = 2;
  localparam int IN_SLEEP_BIT   = 3;
  localparam int IN_CAPTURE_BIT = 4;
  localparam int IN_FRAME_BIT   = 5;

  // Bit positions of the result fields in out_tdata.
  localparam int OUT_LED_BIT    = 0;
  localparam int OUT_LIGHT_BIT  = 1;
  localparam int OUT_MODE_BIT   = 2;
  localparam int OUT_FRESET_BIT = 3;
  localparam int OUT_STALL_BIT  = 4;

  typedef struct packed {
    logic frame_seen;
    logic capturing;
    logic sleeping;
    logic ready_req;
    logic reset_btn;
    logic mode_btn;
  } tick_t;

  typedef struct packed {
    logic stall_reboot;
    logic factory_reset;
    logic mode_switch;
    logic light_check;
    logic led_level;
  } result_t;

endpackage : cbs_pkg

`default_nettype wire

// ===== hdl/camera_board_supervisor_core.sv =====
`default_nettype none

// Camera board supervisor. Each input transfer is one poll tick carrying the
// button levels and the ready, sleeping, capturing and frame-seen flags; each
// tick yields exactly one result transfer with the LED level, the light-check,
// mode-switch and factory-reset pulses, and the capture-stall flag. The block
// has a two-stage pipeline: an input register holds the accepted tick, the
// counter updates and limit compares run in combinational logic, and the
// result lands in an output register. A new tick is taken every clock cycle
// as long as the result side keeps up; out_tvalid rises once the tick has
// passed the input register and its result the output register.
// Configuration writes on the cfg_ port are always
// accepted and must only be issued while no tick is in flight. A limit
// register written as zero behaves as a limit of one, and writes to an index
// past the last register are dropped.
module camera_board_supervisor_core
  import cbs_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,

  input  wire                     in_tvalid,
  output logic                    in_tready,
  // [0] mode_btn, [1] reset_btn, [2] ready_req, [3] sleeping,
  // [4] capturing, [5] frame_seen, [7:6] zero
  input  wire  [IN_TDATA_W-1:0]   in_tdata,

  output logic                    out_tvalid,
  input  wire                     out_tready,
  // [0] led_level, [1] light_check, [2] mode_switch, [3] factory_reset,
  // [4] stall_reboot, [7:5] zero
  output logic [OUT_TDATA_W-1:0]  out_tdata,

  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire  [CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers.
  logic               variant_r;
  logic [MODE_W-1:0]  press_ticks_r;
  logic [HOLD_W-1:0]  hold_ticks_r;
  logic [BLINK_W-1:0] blink_ticks_r;
  logic [LIGHT_W-1:0] light_ticks_r;
  logic [STALL_W-1:0] stall_ticks_r;

  // Supervisor state.
  logic [STALL_W-1:0] stall_count_r, stall_count_nxt;
  logic [BLINK_W-1:0] blink_count_r, blink_count_nxt;
  logic [LIGHT_W-1:0] light_count_r, light_count_nxt;
  logic [MODE_W-1:0]  mode_count_r,  mode_count_nxt;
  logic [HOLD_W-1:0]  hold_count_r,  hold_count_nxt;
  logic               reset_done_r,  reset_done_nxt;
  logic               led_r,         led_nxt;

  // Pipeline registers.
  logic    tick_valid_r;
  tick_t   tick_r;
  logic    out_valid_r;
  result_t result_r, result_nxt;

  // The compute stage moves forward whenever it holds a tick and the output
  // register is free or its result is being taken in this cycle.
  logic advance;
  assign advance   = tick_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !tick_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, result_r};

  // Effective limits: a value of zero acts as one.
  logic [MODE_W-1:0]  press_lim;
  logic [HOLD_W-1:0]  hold_lim;
  logic [BLINK_W-1:0] blink_lim;
  logic [LIGHT_W-1:0] light_lim;
  logic [STALL_W-1:0] stall_lim;
  assign press_lim = (press_ticks_r == '0) ? MODE_W'(1)  : press_ticks_r;
  assign hold_lim  = (hold_ticks_r  == '0) ? HOLD_W'(1)  : hold_ticks_r;
  assign blink_lim = (blink_ticks_r == '0) ? BLINK_W'(1) : blink_ticks_r;
  assign light_lim = (light_ticks_r == '0) ? LIGHT_W'(1) : light_ticks_r;
  assign stall_lim = (stall_ticks_r == '0) ? STALL_W'(1) : stall_ticks_r;

  // Saturating increments of each counter.
  logic [STALL_W-1:0] stall_inc;
  logic [BLINK_W-1:0] blink_inc;
  logic [LIGHT_W-1:0] light_inc;
  logic [MODE_W-1:0]  mode_inc;
  logic [HOLD_W-1:0]  hold_inc;
  assign stall_inc = (&stall_count_r) ? stall_count_r : stall_count_r + STALL_W'(1);
  assign blink_inc = (&blink_count_r) ? blink_count_r : blink_count_r + BLINK_W'(1);
  assign light_inc = (&light_count_r) ? light_count_r : light_count_r + LIGHT_W'(1);
  assign mode_inc  = (&mode_count_r)  ? mode_count_r  : mode_count_r  + MODE_W'(1);
  assign hold_inc  = (&hold_count_r)  ? hold_count_r  : hold_count_r  + HOLD_W'(1);

  always_comb begin
    stall_count_nxt = stall_count_r;
    blink_count_nxt = blink_count_r;
    light_count_nxt = light_count_r;
    mode_count_nxt  = mode_count_r;
    hold_count_nxt  = hold_count_r;
    reset_done_nxt  = reset_done_r;
    led_nxt         = led_r;
    result_nxt      = '0;

    // The stall counter runs in every tick, whatever the power state.
    if (tick_r.frame_seen) begin
      stall_count_nxt = '0;
    end else if (tick_r.capturing) begin
      stall_count_nxt = stall_inc;
    end
    result_nxt.stall_reboot = tick_r.capturing && (stall_count_nxt >= stall_lim);

    if (tick_r.sleeping) begin
      led_nxt = 1'b0;
    end else if (!tick_r.ready_req) begin
      // Start-up: blink the LED and drop any button hold in progress.
      if (blink_inc >= blink_lim) begin
        blink_count_nxt = '0;
        led_nxt         = !led_r;
      end else begin
        blink_count_nxt = blink_inc;
      end
      mode_count_nxt = '0;
      hold_count_nxt = '0;
    end else begin
      if (!variant_r) begin
        // Pan-tilt board: LED dark, periodic light checks, no mode button.
        led_nxt = 1'b0;
        if (light_inc >= light_lim) begin
          light_count_nxt        = '0;
          result_nxt.light_check = 1'b1;
        end else begin
          light_count_nxt = light_inc;
        end
      end else begin
        led_nxt = 1'b1;
      end

      // The mode switch fires on release after a long enough press.
      if (tick_r.mode_btn && variant_r) begin
        mode_count_nxt = mode_inc;
      end else begin
        result_nxt.mode_switch = (mode_count_r >= press_lim);
        mode_count_nxt         = '0;
      end

      // Factory reset fires once per hold; release rearms it.
      if (tick_r.reset_btn) begin
        hold_count_nxt = hold_inc;
        if (!reset_done_r && (hold_inc >= hold_lim)) begin
          reset_done_nxt           = 1'b1;
          result_nxt.factory_reset = 1'b1;
        end
      end else begin
        hold_count_nxt = '0;
        reset_done_nxt = 1'b0;
      end
    end

    result_nxt.led_level = led_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r     <= 1'b0;
      press_ticks_r <= MODE_W'(2);
      hold_ticks_r  <= HOLD_W'(60);
      blink_ticks_r <= BLINK_W'(5);
      light_ticks_r <= LIGHT_W'(100);
      stall_ticks_r <= STALL_W'(600);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAMERA_VARIANT:    variant_r     <= cfg_data[0];
        REG_PRESS_TICKS:       press_ticks_r <= cfg_data[MODE_W-1:0];
        REG_HOLD_TICKS:        hold_ticks_r  <= cfg_data[HOLD_W-1:0];
        REG_BLINK_TICKS:       blink_ticks_r <= cfg_data[BLINK_W-1:0];
        REG_LIGHT_CHECK_TICKS: light_ticks_r <= cfg_data[LIGHT_W-1:0];
        REG_STALL_TICKS:       stall_ticks_r <= cfg_data[STALL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      stall_count_r <= '0;
      blink_count_r <= '0;
      light_count_r <= '0;
      mode_count_r  <= '0;
      hold_count_r  <= '0;
      reset_done_r  <= 1'b0;
      led_r         <= 1'b0;
    end else begin
      if (in_tready) begin
        tick_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r   <= 1'b1;
        stall_count_r <= stall_count_nxt;
        blink_count_r <= blink_count_nxt;
        light_count_r <= light_count_nxt;
        mode_count_r  <= mode_count_nxt;
        hold_count_r  <= hold_count_nxt;
        reset_done_r  <= reset_done_nxt;
        led_r         <= led_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      tick_r <= tick_t'(in_tdata[$bits(tick_t)-1:0]);
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

endmodule : camera_board_supervisor_core

`default_nettype wire

// ===== hdl/cbs_checker.sv =====
`default_nettype none

module cbs_checker
  import cbs_pkg::*;
(
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_tready,
  input wire [OUT_TDATA_W-1:0]  out_tdata,
  input wire                    out_tvalid,
  input wire                    out_tready
);

  logic out_xfer;
  logic last_freset_r;
  assign out_xfer = out_tvalid && out_tready;

  // Remembers whether the previous result transfer carried a factory reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_freset_r <= 1'b0;
    end else if (out_xfer) begin
      last_freset_r <= out_tdata[OUT_FRESET_BIT];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");

  a_light_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_LIGHT_BIT] |-> !out_tdata[OUT_LED_BIT])
    else $error("light check with LED lit");

  a_freset_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && last_freset_r |-> !out_tdata[OUT_FRESET_BIT])
    else $error("factory reset repeated in consecutive results");

endmodule : cbs_checker

bind camera_board_supervisor_core cbs_checker u_cbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

// ===== tb/camera_board_supervisor_core_tb.sv =====
`timescale 1ns / 1ps

module camera_board_supervisor_core_tb;
  import cbs_pkg::*;

  // Camera variants as carried in the variant register.
  localparam logic VARIANT_PAN_TILT = 1'b0;
  localparam logic VARIANT_FIXED    = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [0] mode_btn, [1] reset_btn, [2] ready_req, [3] sleeping,
  // [4] capturing, [5] frame_seen, [7:6] zero
  logic [IN_TDATA_W-1:0]  in_tdata = '0;

  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [0] led_level, [1] light_check, [2] mode_switch, [3] factory_reset,
  // [4] stall_reboot, [7:5] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  camera_board_supervisor_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Poll ticks waiting to be sent, and the supervisor results that the
  // accepted ticks are predicted to produce, oldest first.
  tick_t   tick_queue[$];
  result_t result_queue[$];
  int      ticks_queued = 0;
  int      results_seen = 0;
  int      n_fail = 0;

  // Idle behavior of each side, switched between phases.
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;

  string result_field[5];

  // Shadow copy of the configuration registers, at their reset values.
  logic        set_variant = VARIANT_PAN_TILT;
  logic [7:0]  set_press   = 8'd2;
  logic [9:0]  set_hold    = 10'd60;
  logic [7:0]  set_blink   = 8'd5;
  logic [11:0] set_light   = 12'd100;
  logic [15:0] set_stall   = 16'd600;

  // Shadow copy of the supervisor counters and flags, all cleared by reset.
  logic [15:0] cnt_stall   = '0;
  logic [7:0]  cnt_blink   = '0;
  logic [11:0] cnt_light   = '0;
  logic [7:0]  cnt_mode    = '0;
  logic [9:0]  cnt_reset   = '0;
  logic        reset_fired = 1'b0;
  logic        led_on      = 1'b0;

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // A limit register holding zero behaves as a limit of one.
  function automatic int floor_one(int v);
    return (v == 0) ? 1 : v;
  endfunction

  // Random idle length: mostly none, sometimes short, rarely a long gap.
  function automatic int idle_len(bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advances the shadow supervisor by one poll tick and returns its result.
  function automatic result_t supervise_tick(tick_t t);
    result_t r;
    logic    mode_on;
    r = '0;
    mode_on = t.mode_btn;

    // The stall counter runs in every tick, asleep or not.
    if (t.frame_seen) cnt_stall = '0;
    else if (t.capturing && cnt_stall != '1) cnt_stall = cnt_stall + 1'b1;
    r.stall_reboot = t.capturing && (int'(cnt_stall) >= floor_one(set_stall));

    if (t.sleeping) begin
      led_on = 1'b0;
    end else if (!t.ready_req) begin
      // Start-up blink; both hold counts clear, the factory-reset latch stays.
      if (cnt_blink != '1) cnt_blink = cnt_blink + 1'b1;
      if (int'(cnt_blink) >= floor_one(set_blink)) begin
        cnt_blink = '0;
        led_on = ~led_on;
      end
      cnt_mode = '0;
      cnt_reset = '0;
    end else begin
      if (set_variant == VARIANT_PAN_TILT) begin
        // Pan-tilt: LED dark, periodic light checks, mode button ignored.
        led_on = 1'b0;
        if (cnt_light != '1) cnt_light = cnt_light + 1'b1;
        if (int'(cnt_light) >= floor_one(set_light)) begin
          cnt_light = '0;
          r.light_check = 1'b1;
        end
        mode_on = 1'b0;
      end else begin
        led_on = 1'b1;
      end

      // A mode switch fires on release after a long enough press.
      if (mode_on) begin
        if (cnt_mode != '1) cnt_mode = cnt_mode + 1'b1;
      end else begin
        if (int'(cnt_mode) >= floor_one(set_press)) r.mode_switch = 1'b1;
        cnt_mode = '0;
      end

      // Factory reset fires once per hold; releasing the button rearms it.
      if (t.reset_btn) begin
        if (cnt_reset != '1) cnt_reset = cnt_reset + 1'b1;
        if (!reset_fired && int'(cnt_reset) >= floor_one(set_hold)) begin
          reset_fired = 1'b1;
          r.factory_reset = 1'b1;
        end
      end else begin
        cnt_reset = '0;
        reset_fired = 1'b0;
      end
    end

    r.led_level = led_on;
    return r;
  endfunction

  // Sender: presents queued ticks, predicts the result of each accepted one.
  always @(posedge clk) begin : tick_sender
    int gap;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap = 0;
    end else begin
      if (in_tvalid && in_tready)
        result_queue.push_back(supervise_tick(tick_t'(in_tdata[$bits(tick_t)-1:0])));
      if (!in_tvalid || in_tready) begin
        if (gap > 0) begin
          gap--;
          in_tvalid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          in_tdata <= IN_TDATA_W'(tick_queue.pop_front());
          in_tvalid <= 1'b1;
          gap = idle_len(tx_idle);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every result transfer against the oldest prediction and
  // throttles out_tready. At most twice in the run it holds off for a long
  // stretch while ticks are still queued, so that the pipeline fills and
  // in_tready drops.
  always @(posedge clk) begin : result_checker
    result_t got;
    result_t want;
    logic    ready_next;
    int      stall;
    int      hold;
    int      holds_done;
    int      hold_at;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall = 0;
      hold = 0;
      holds_done = 0;
      hold_at = 400;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (result_queue.size() == 0) begin
          $error("result transfer 0x%02h with no tick outstanding", out_tdata);
          n_fail++;
        end else begin
          want = result_queue.pop_front();
          for (int i = 0; i < $bits(result_t); i++) begin
            if (got[i] !== want[i]) begin
              $error("%s: expected %0b, actual %0b", result_field[i], want[i], got[i]);
              n_fail++;
            end
          end
        end
      end

      if (holds_done < 2 && results_seen >= hold_at && tick_queue.size() > 20) begin
        hold = 240;
        holds_done++;
        hold_at = results_seen + 700;
      end

      if (hold > 0) begin
        hold--;
        ready_next = 1'b0;
      end else if (stall > 0) begin
        stall--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
        stall = idle_len(rx_idle);
      end
      out_tready <= ready_next;
    end
  end

  task automatic queue_tick(bit m, bit r, bit rd, bit sl, bit cap, bit fr);
    tick_t t;
    t.mode_btn   = m;
    t.reset_btn  = r;
    t.ready_req  = rd;
    t.sleeping   = sl;
    t.capturing  = cap;
    t.frame_seen = fr;
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  // Returns at a falling edge once every tick is sent and every result seen.
  task automatic wait_drained();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_tvalid || result_queue.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    // Only the register's own width is kept; unknown indexes are dropped.
    case (idx)
      REG_CAMERA_VARIANT:    set_variant = val[0];
      REG_PRESS_TICKS:       set_press   = val[7:0];
      REG_HOLD_TICKS:        set_hold    = val[9:0];
      REG_BLINK_TICKS:       set_blink   = val[7:0];
      REG_LIGHT_CHECK_TICKS: set_light   = val[11:0];
      REG_STALL_TICKS:       set_stall   = val[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Writes every register, then an index past the end of the register map.
  task automatic load_settings(logic [CFG_DATA_W-1:0] variant, logic [CFG_DATA_W-1:0] press,
                               logic [CFG_DATA_W-1:0] hold, logic [CFG_DATA_W-1:0] blink,
                               logic [CFG_DATA_W-1:0] light, logic [CFG_DATA_W-1:0] stall);
    write_reg(REG_CAMERA_VARIANT, variant);
    write_reg(REG_PRESS_TICKS, press);
    write_reg(REG_HOLD_TICKS, hold);
    write_reg(REG_BLINK_TICKS, blink);
    write_reg(REG_LIGHT_CHECK_TICKS, light);
    write_reg(REG_STALL_TICKS, stall);
    write_reg(CFG_INDEX_W'(REG_STALL_TICKS + $urandom_range(1, 2)), CFG_DATA_W'($urandom));
    @(negedge clk);
  endtask

  // Small random limit, now and then with garbage above the register width.
  function automatic logic [CFG_DATA_W-1:0] with_junk(int v, int width);
    int keep;
    keep = (1 << width) - 1;
    if (chance(25)) return CFG_DATA_W'(v | ($urandom & ~keep));
    return CFG_DATA_W'(v);
  endfunction

  function automatic int upto(int hi);
    return $urandom_range(1, (hi > 40) ? 40 : hi);
  endfunction

  // One stretch of ticks. Most are well-formed button and capture sequences
  // sized around the current limits; a tick inside a sequence is now and
  // then broken by a sleeping or not-ready tick, and some stretches are noise.
  task automatic queue_episode();
    int n;
    bit b;
    case ($urandom_range(0, 9))
      0, 1: begin
        n = $urandom_range(0, floor_one(set_press) + 2);
        repeat (n) begin
          b = chance(5);
          queue_tick(1'b1, chance(10), !b, b && chance(50), chance(70), chance(15));
        end
        queue_tick(1'b0, chance(10), 1'b1, 1'b0, chance(70), chance(15));
      end
      2, 3: begin
        n = upto(floor_one(set_hold) + 3);
        repeat (n) begin
          b = chance(5);
          queue_tick(chance(30), 1'b1, !b, b && chance(50), chance(70), chance(15));
        end
        queue_tick(chance(30), 1'b0, 1'b1, 1'b0, chance(70), chance(15));
      end
      4: begin
        n = upto(2 * floor_one(set_blink) + 2);
        repeat (n)
          queue_tick(chance(50), chance(50), 1'b0, chance(10), chance(50), chance(20));
      end
      5: begin
        n = upto(floor_one(set_stall) + 4);
        repeat (n) queue_tick(chance(20), chance(20), chance(80), chance(10), 1'b1, chance(3));
        queue_tick(1'b0, 1'b0, chance(80), 1'b0, 1'b1, 1'b1);
      end
      6: begin
        n = upto(2 * floor_one(set_light) + 2);
        repeat (n) queue_tick(1'b0, 1'b0, 1'b1, 1'b0, chance(50), chance(20));
      end
      default: begin
        n = $urandom_range(1, 6);
        repeat (n)
          queue_tick(chance(50), chance(50), chance(50), chance(50), chance(50), chance(50));
      end
    endcase
  endtask

  task automatic queue_random(int count);
    int start;
    start = ticks_queued;
    while (ticks_queued - start < count) queue_episode();
  endtask

  initial begin : stimulus
    result_field[OUT_LED_BIT]    = "led_level";
    result_field[OUT_LIGHT_BIT]  = "light_check";
    result_field[OUT_MODE_BIT]   = "mode_switch";
    result_field[OUT_FRESET_BIT] = "factory_reset";
    result_field[OUT_STALL_BIT]  = "stall_reboot";

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values of the registers, checked with plain noise and no idling.
    repeat (40) queue_tick(chance(50), chance(50), chance(50), chance(50), chance(50), chance(50));
    wait_drained();

    // Directed part. Fixed variant with short limits; garbage above the width
    // of some registers, a zero blink limit that must act as one.
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    load_settings(16'h8001, 16'h1202, 16'hFC03, 16'h0000, 16'h0001, 16'h0002);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // not ready, LED toggles
    queue_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);  // not ready, buttons ignored
    queue_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);  // every flag: asleep wins
    queue_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);  // asleep, stall count runs
    queue_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);  // asleep, stall flag rises
    queue_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);  // mode press held
    queue_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);  // release: switch
    queue_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);  // press too short
    queue_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);  // release: no switch
    repeat (4) queue_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);  // one reset pulse
    queue_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);  // frame while idle
    wait_drained();
    write_reg(REG_CAMERA_VARIANT, {15'h7FFF, VARIANT_PAN_TILT});
    write_reg(REG_LIGHT_CHECK_TICKS, 16'hF002);
    @(negedge clk);
    queue_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);  // light strobe, mode ignored
    queue_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);  // release: no switch
    repeat (3) queue_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);  // reset in pan-tilt
    queue_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);  // not ready clears holds
    queue_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
    wait_drained();

    // Random phases with small limits, so that the limits are crossed often.
    // Idling varies per phase; odd phases also pause the sender midway until
    // every result is back.
    for (int p = 0; p < 6; p++) begin
      tx_idle = (p == 1 || p >= 3);
      rx_idle = (p >= 2);
      load_settings(with_junk($urandom_range(0, 1), 1), with_junk($urandom_range(0, 6), 8),
                    with_junk($urandom_range(0, 12), 10), with_junk($urandom_range(0, 6), 8),
                    with_junk($urandom_range(0, 10), 12), CFG_DATA_W'($urandom_range(0, 15)));
      if (p % 2 == 1) begin
        queue_random(65);
        wait_drained();
      end
      queue_random(65);
      wait_drained();
    end

    // Every limit at its maximum: both buttons held long enough to saturate
    // both hold counters, then released.
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (1030) queue_tick(1'b1, 1'b1, 1'b1, 1'b0, chance(90), chance(1));
    queue_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    queue_random(20);
    wait_drained();

    // Every register written as zero, so each limit acts as one.
    rx_idle = 1'b0;
    load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_random(100);
    wait_drained();

    repeat (8) @(posedge clk);
    if (n_fail == 0 && result_queue.size() == 0) begin
      $display("camera_board_supervisor_core regression: pass");
    end else begin
      $display("camera_board_supervisor_core regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("camera_board_supervisor_core regression: fail");
    $finish;
  end

endmodule
